// File: design/lav_pkg.sv
// Shared types and constants for the look-at view matrix block.
package lav_pkg;

   localparam int COORD_W = 32;
   localparam int UNIT_W  = 32;
   localparam int NORM_W  = 30;
   localparam int WIDE_W  = 64;
   localparam int COL_W   = 2;
   localparam int COLS    = 4;

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS - 1);
   localparam logic [COL_W-1:0] ITEM_GAP = COL_W'(COLS - 1);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec3_type;

   typedef struct packed {
      vec3_type eye;
      vec3_type up;
   } cam_side_type;

   typedef struct packed {
      vec3_type eye;
      vec3_type fwd;
      logic     degen;
   } fwd_side_type;

   typedef struct packed {
      vec3_type eye;
      vec3_type fwd;
      vec3_type rgt;
      logic     degen;
   } rgt_side_type;

endpackage

// File: design/lav_unitize.sv
// Pipelined vector normalizer: range shift, squares, square root and division.
module lav_unitize #(
   parameter int IW        = 33,
   parameter int SW        = 1,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [IW-1:0]                in_vec [3],
   input  logic [SW-1:0]                       in_side,
   output logic                                out_valid,
   output logic signed [lav_pkg::UNIT_W-1:0]   out_unit [3],
   output logic                                out_zero,
   output logic [SW-1:0]                       out_side
);

   localparam int NM         = lav_pkg::NORM_W;
   localparam int NG         = (IW + 7) / 8;
   localparam int PW         = $clog2(NG * 8);
   localparam int SQ_W       = 2 * NM + 2;
   localparam int RT_W       = SQ_W + 2;
   localparam int SQ_ITER    = SQ_W / 2 + 1;
   localparam int SQ_STAGES  = SQ_ITER / 2;
   localparam int LEN_W      = NM + 1;
   localparam int DW         = NM + FRAC_BITS + 1;
   localparam int QW         = FRAC_BITS + 1;
   localparam logic [PW-1:0] POS_TOP = PW'(NM);
   localparam logic [PW-1:0] POS_FIT = PW'(NM - 1);

   // Stage 1: magnitudes.
   logic          v1_ff;
   logic [IW-1:0] mag1_ff [3];
   logic [2:0]    neg1_ff;
   logic [SW-1:0] side1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mag1_ff[i] <= in_vec[i][IW-1] ? IW'(-in_vec[i]) : IW'(in_vec[i]);
         neg1_ff[i] <= in_vec[i][IW-1];
      end
      side1_ff <= in_side;
   end

   // Stage 2: leading one per byte of the combined magnitude.
   logic [NG*8-1:0] orw;
   logic [NG-1:0]   gnz;
   logic [2:0]      gpos [NG];

   always_comb begin
      orw = (NG*8)'(mag1_ff[0] | mag1_ff[1] | mag1_ff[2]);
      for (int g = 0; g < NG; g++) begin
         gnz[g]  = 1'b0;
         gpos[g] = 3'd0;
         for (int j = 0; j < 8; j++) begin
            if (orw[g*8+j]) begin
               gnz[g]  = 1'b1;
               gpos[g] = 3'(j);
            end
         end
      end
   end

   logic          v2_ff;
   logic [NG-1:0] gnz2_ff;
   logic [2:0]    gpos2_ff [NG];
   logic [IW-1:0] mag2_ff [3];
   logic [2:0]    neg2_ff;
   logic [SW-1:0] side2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      gnz2_ff  <= gnz;
      gpos2_ff <= gpos;
      mag2_ff  <= mag1_ff;
      neg2_ff  <= neg1_ff;
      side2_ff <= side1_ff;
   end

   // Stage 3: position of the leading one.
   logic [PW-1:0] pos;

   always_comb begin
      pos = '0;
      for (int g = 0; g < NG; g++) begin
         if (gnz2_ff[g]) pos = PW'(g * 8 + int'(gpos2_ff[g]));
      end
   end

   logic          v3_ff;
   logic [PW-1:0] pos3_ff;
   logic          zero3_ff;
   logic [IW-1:0] mag3_ff [3];
   logic [2:0]    neg3_ff;
   logic [SW-1:0] side3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      pos3_ff  <= pos;
      zero3_ff <= ~(|gnz2_ff);
      mag3_ff  <= mag2_ff;
      neg3_ff  <= neg2_ff;
      side3_ff <= side2_ff;
   end

   // Stage 4: shift so the largest magnitude lands in [2^29, 2^30).
   logic [IW+NM-1:0] wide [3];
   logic [NM-1:0]    norm [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wide[i] = (IW+NM)'(mag3_ff[i]);
         if (pos3_ff >= POS_TOP) norm[i] = NM'(wide[i] >> (pos3_ff - POS_FIT));
         else norm[i] = NM'(wide[i] << (POS_FIT - pos3_ff));
      end
   end

   logic          v4_ff;
   logic [NM-1:0] m4_ff [3];
   logic          zero4_ff;
   logic [2:0]    neg4_ff;
   logic [SW-1:0] side4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
   end

   always_ff @(posedge clock) begin
      m4_ff    <= norm;
      zero4_ff <= zero3_ff;
      neg4_ff  <= neg3_ff;
      side4_ff <= side3_ff;
   end

   // Stage 5: squares.
   logic            v5_ff;
   logic [2*NM-1:0] sq5_ff [3];
   logic [NM-1:0]   m5_ff [3];
   logic            zero5_ff;
   logic [2:0]      neg5_ff;
   logic [SW-1:0]   side5_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else v5_ff <= v4_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) sq5_ff[i] <= m4_ff[i] * m4_ff[i];
      m5_ff    <= m4_ff;
      zero5_ff <= zero4_ff;
      neg5_ff  <= neg4_ff;
      side5_ff <= side4_ff;
   end

   // Stage 6 feeds the square root pipeline with the sum of squares.
   logic            sv_ff   [0:SQ_STAGES];
   logic [RT_W-1:0] sn_ff   [0:SQ_STAGES];
   logic [RT_W-1:0] sr_ff   [0:SQ_STAGES];
   logic [NM-1:0]   sm_ff   [0:SQ_STAGES][3];
   logic            sz_ff   [0:SQ_STAGES];
   logic [2:0]      sneg_ff [0:SQ_STAGES];
   logic [SW-1:0]   sside_ff[0:SQ_STAGES];

   always_ff @(posedge clock) begin
      if (reset) sv_ff[0] <= 1'b0;
      else sv_ff[0] <= v5_ff;
   end

   always_ff @(posedge clock) begin
      sn_ff[0]    <= RT_W'(SQ_W'(sq5_ff[0]) + SQ_W'(sq5_ff[1]) + SQ_W'(sq5_ff[2]));
      sr_ff[0]    <= '0;
      sm_ff[0]    <= m5_ff;
      sz_ff[0]    <= zero5_ff;
      sneg_ff[0]  <= neg5_ff;
      sside_ff[0] <= side5_ff;
   end

   // One step of the bit-pair square root; returns {remainder, root}.
   function automatic logic [2*RT_W-1:0] sqrt_step(input logic [RT_W-1:0] n,
                                                   input logic [RT_W-1:0] r,
                                                   input int sh);
      logic [RT_W-1:0] b;
      logic [RT_W-1:0] t;
      b = RT_W'(1) << sh;
      t = r + b;
      if (n >= t) return {n - t, (r >> 1) + b};
      return {n, r >> 1};
   endfunction

   for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sqrt
      localparam int SH0 = SQ_W - 4 * s;
      logic [RT_W-1:0] n_mid;
      logic [RT_W-1:0] r_mid;
      logic [RT_W-1:0] n_out;
      logic [RT_W-1:0] r_out;

      assign {n_mid, r_mid} = sqrt_step(sn_ff[s], sr_ff[s], SH0);
      assign {n_out, r_out} = sqrt_step(n_mid, r_mid, SH0 - 2);

      always_ff @(posedge clock) begin
         if (reset) sv_ff[s+1] <= 1'b0;
         else sv_ff[s+1] <= sv_ff[s];
      end

      always_ff @(posedge clock) begin
         sn_ff[s+1]    <= n_out;
         sr_ff[s+1]    <= r_out;
         sm_ff[s+1]    <= sm_ff[s];
         sz_ff[s+1]    <= sz_ff[s];
         sneg_ff[s+1]  <= sneg_ff[s];
         sside_ff[s+1] <= sside_ff[s];
      end
   end

   // Restoring division, one quotient bit per stage, three lanes.
   logic             dv_ff   [0:QW];
   logic [DW-1:0]    dn_ff   [0:QW][3];
   logic [QW-1:0]    dq_ff   [0:QW][3];
   logic [LEN_W-1:0] dl_ff   [0:QW];
   logic             dz_ff   [0:QW];
   logic [2:0]       dneg_ff [0:QW];
   logic [SW-1:0]    dside_ff[0:QW];
   logic [LEN_W-1:0] len;

   assign len = sr_ff[SQ_STAGES][LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else dv_ff[0] <= sv_ff[SQ_STAGES];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dn_ff[0][i] <= (DW'(sm_ff[SQ_STAGES][i]) << FRAC_BITS) + DW'(len >> 1);
         dq_ff[0][i] <= '0;
      end
      dl_ff[0]    <= len;
      dz_ff[0]    <= sz_ff[SQ_STAGES];
      dneg_ff[0]  <= sneg_ff[SQ_STAGES];
      dside_ff[0] <= sside_ff[SQ_STAGES];
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      localparam int BIT = FRAC_BITS - j;
      logic [DW-1:0] dsr;

      assign dsr = DW'(dl_ff[j]) << BIT;

      always_ff @(posedge clock) begin
         if (reset) dv_ff[j+1] <= 1'b0;
         else dv_ff[j+1] <= dv_ff[j];
      end

      always_ff @(posedge clock) begin
         for (int i = 0; i < 3; i++) begin
            if (dn_ff[j][i] >= dsr) begin
               dn_ff[j+1][i] <= dn_ff[j][i] - dsr;
               dq_ff[j+1][i] <= {dq_ff[j][i][QW-2:0], 1'b1};
            end else begin
               dn_ff[j+1][i] <= dn_ff[j][i];
               dq_ff[j+1][i] <= {dq_ff[j][i][QW-2:0], 1'b0};
            end
         end
         dl_ff[j+1]    <= dl_ff[j];
         dz_ff[j+1]    <= dz_ff[j];
         dneg_ff[j+1]  <= dneg_ff[j];
         dside_ff[j+1] <= dside_ff[j];
      end
   end

   // Output stage: put the signs back.
   logic                              ov_ff;
   logic signed [lav_pkg::UNIT_W-1:0] ou_ff [3];
   logic                              oz_ff;
   logic [SW-1:0]                     os_ff;

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else ov_ff <= dv_ff[QW];
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         ou_ff[i] <= dneg_ff[QW][i] ? -lav_pkg::UNIT_W'(dq_ff[QW][i])
                                    : lav_pkg::UNIT_W'(dq_ff[QW][i]);
      end
      oz_ff <= dz_ff[QW];
      os_ff <= dside_ff[QW];
   end

   assign out_valid = ov_ff;
   assign out_unit  = ou_ff;
   assign out_zero  = oz_ff;
   assign out_side  = os_ff;

endmodule

// File: design/lav_cross.sv
// Two-stage cross product of two 32-bit vectors with exact 64-bit components.
module lav_cross #(
   parameter int SW = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  lav_pkg::vec3_type         in_a,
   input  lav_pkg::vec3_type         in_b,
   input  logic [SW-1:0]             in_side,
   output logic                      out_valid,
   output lav_pkg::wide_type         out_c [3],
   output logic [SW-1:0]             out_side
);

   logic              p_valid_ff;
   lav_pkg::wide_type prod_ff [6];
   logic [SW-1:0]     p_side_ff;
   logic              c_valid_ff;
   lav_pkg::wide_type c_ff [3];
   logic [SW-1:0]     c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         p_valid_ff <= in_valid;
         c_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff[0] <= in_a.y * in_b.z;
      prod_ff[1] <= in_a.z * in_b.y;
      prod_ff[2] <= in_a.z * in_b.x;
      prod_ff[3] <= in_a.x * in_b.z;
      prod_ff[4] <= in_a.x * in_b.y;
      prod_ff[5] <= in_a.y * in_b.x;
      p_side_ff  <= in_side;
      c_ff[0]    <= prod_ff[0] - prod_ff[1];
      c_ff[1]    <= prod_ff[2] - prod_ff[3];
      c_ff[2]    <= prod_ff[4] - prod_ff[5];
      c_side_ff  <= p_side_ff;
   end

   assign out_valid = c_valid_ff;
   assign out_c     = c_ff;
   assign out_side  = c_side_ff;

endmodule

// File: design/lav_emit.sv
// True up, translation column and the column-by-column result sequencer.
module lav_emit #(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  lav_pkg::wide_type              in_uraw [3],
   input  lav_pkg::rgt_side_type          in_side,
   output logic                           out_valid,
   output logic [lav_pkg::COL_W-1:0]      out_column,
   output lav_pkg::coord_type             out_row [lav_pkg::COLS],
   output logic                           out_last,
   output logic                           out_degen
);

   localparam lav_pkg::coord_type ONE = lav_pkg::coord_type'(1) << FRAC_BITS;
   localparam lav_pkg::wide_type  HALF = lav_pkg::wide_type'(1) << (FRAC_BITS - 1);
   localparam lav_pkg::wide_type  S32_MAX = lav_pkg::wide_type'(32'sh7FFF_FFFF);
   localparam lav_pkg::wide_type  S32_MIN = -lav_pkg::wide_type'(33'sh0_8000_0000);

   // Drop the fraction bits, rounding half away from zero.
   function automatic lav_pkg::wide_type round_shift(input lav_pkg::wide_type x);
      logic [lav_pkg::WIDE_W-1:0] m;
      m = x[lav_pkg::WIDE_W-1] ? lav_pkg::WIDE_W'(-x) : lav_pkg::WIDE_W'(x);
      m = (m + lav_pkg::WIDE_W'(HALF)) >> FRAC_BITS;
      return x[lav_pkg::WIDE_W-1] ? -$signed(m) : $signed(m);
   endfunction

   function automatic lav_pkg::coord_type sat32(input lav_pkg::wide_type x);
      if (x > S32_MAX) return lav_pkg::coord_type'(S32_MAX);
      if (x < S32_MIN) return lav_pkg::coord_type'(S32_MIN);
      return lav_pkg::coord_type'(x);
   endfunction

   function automatic lav_pkg::coord_type pick(input lav_pkg::vec3_type v,
                                               input logic [lav_pkg::COL_W-1:0] k);
      unique case (k)
         2'd0:    return v.x;
         2'd1:    return v.y;
         default: return v.z;
      endcase
   endfunction

   // Stage 1: true up vector.
   logic                  v1_ff;
   lav_pkg::vec3_type     u1_ff;
   lav_pkg::rgt_side_type s1_ff;

   // Stage 2: dot product terms.
   logic                  v2_ff;
   lav_pkg::wide_type     pr_ff [3];
   lav_pkg::wide_type     pu_ff [3];
   lav_pkg::wide_type     pf_ff [3];
   lav_pkg::vec3_type     u2_ff;
   lav_pkg::rgt_side_type s2_ff;

   // Stage 3: dot products.
   logic                  v3_ff;
   lav_pkg::wide_type     dr_ff, du_ff, df_ff;
   lav_pkg::vec3_type     u3_ff;
   lav_pkg::rgt_side_type s3_ff;

   // Stage 4: rounded dot products.
   logic                  v4_ff;
   lav_pkg::wide_type     tr_ff, tu_ff, tf_ff;
   lav_pkg::vec3_type     u4_ff;
   lav_pkg::rgt_side_type s4_ff;

   // Stage 5: saturated translation.
   logic                  v5_ff;
   lav_pkg::coord_type    tx_ff, ty_ff, tz_ff;
   lav_pkg::vec3_type     u5_ff;
   lav_pkg::rgt_side_type s5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      u1_ff.x <= lav_pkg::coord_type'(round_shift(in_uraw[0]));
      u1_ff.y <= lav_pkg::coord_type'(round_shift(in_uraw[1]));
      u1_ff.z <= lav_pkg::coord_type'(round_shift(in_uraw[2]));
      s1_ff   <= in_side;

      pr_ff[0] <= s1_ff.rgt.x * s1_ff.eye.x;
      pr_ff[1] <= s1_ff.rgt.y * s1_ff.eye.y;
      pr_ff[2] <= s1_ff.rgt.z * s1_ff.eye.z;
      pu_ff[0] <= u1_ff.x * s1_ff.eye.x;
      pu_ff[1] <= u1_ff.y * s1_ff.eye.y;
      pu_ff[2] <= u1_ff.z * s1_ff.eye.z;
      pf_ff[0] <= s1_ff.fwd.x * s1_ff.eye.x;
      pf_ff[1] <= s1_ff.fwd.y * s1_ff.eye.y;
      pf_ff[2] <= s1_ff.fwd.z * s1_ff.eye.z;
      u2_ff    <= u1_ff;
      s2_ff    <= s1_ff;

      dr_ff <= pr_ff[0] + pr_ff[1] + pr_ff[2];
      du_ff <= pu_ff[0] + pu_ff[1] + pu_ff[2];
      df_ff <= pf_ff[0] + pf_ff[1] + pf_ff[2];
      u3_ff <= u2_ff;
      s3_ff <= s2_ff;

      tr_ff <= round_shift(dr_ff);
      tu_ff <= round_shift(du_ff);
      tf_ff <= round_shift(df_ff);
      u4_ff <= u3_ff;
      s4_ff <= s3_ff;

      tx_ff <= sat32(-tr_ff);
      ty_ff <= sat32(-tu_ff);
      tz_ff <= sat32(tf_ff);
      u5_ff <= u4_ff;
      s5_ff <= s4_ff;
   end

   // Matrix hold registers and column sequencer.
   lav_pkg::vec3_type             mr_ff, mu_ff, mf_ff;
   lav_pkg::coord_type            mtx_ff, mty_ff, mtz_ff;
   logic                          mdeg_ff;
   logic                          act_ff;
   logic [lav_pkg::COL_W-1:0]     col_ff;

   always_ff @(posedge clock) begin
      if (v5_ff) begin
         mr_ff   <= s5_ff.rgt;
         mu_ff   <= u5_ff;
         mf_ff   <= s5_ff.fwd;
         mtx_ff  <= tx_ff;
         mty_ff  <= ty_ff;
         mtz_ff  <= tz_ff;
         mdeg_ff <= s5_ff.degen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         col_ff <= '0;
      end else if (v5_ff) begin
         act_ff <= 1'b1;
         col_ff <= '0;
      end else if (act_ff) begin
         act_ff <= (col_ff != lav_pkg::LAST_COL);
         col_ff <= col_ff + 1'b1;
      end
   end

   lav_pkg::coord_type row_in [lav_pkg::COLS];

   always_comb begin
      for (int i = 0; i < lav_pkg::COLS; i++) begin
         row_in[i] = (lav_pkg::COL_W'(i) == col_ff) ? ONE : '0;
      end
      if (!mdeg_ff) begin
         if (col_ff == lav_pkg::LAST_COL) begin
            row_in[0] = mtx_ff;
            row_in[1] = mty_ff;
            row_in[2] = mtz_ff;
            row_in[3] = ONE;
         end else begin
            row_in[0] = pick(mr_ff, col_ff);
            row_in[1] = pick(mu_ff, col_ff);
            row_in[2] = -pick(mf_ff, col_ff);
            row_in[3] = '0;
         end
      end
   end

   logic                      ovalid_ff;
   logic [lav_pkg::COL_W-1:0] ocol_ff;
   lav_pkg::coord_type        orow_ff [lav_pkg::COLS];
   logic                      olast_ff;
   logic                      odeg_ff;

   always_ff @(posedge clock) begin
      if (reset) ovalid_ff <= 1'b0;
      else ovalid_ff <= act_ff;
   end

   always_ff @(posedge clock) begin
      ocol_ff  <= col_ff;
      orow_ff  <= row_in;
      olast_ff <= (col_ff == lav_pkg::LAST_COL);
      odeg_ff  <= mdeg_ff;
   end

   assign out_valid  = ovalid_ff;
   assign out_column = ocol_ff;
   assign out_row    = orow_ff;
   assign out_last   = olast_ff;
   assign out_degen  = odeg_ff;

endmodule

// File: design/look_at_view_matrix.sv
// Top level of the look-at view matrix block.
//
// A camera transaction (eye, look target and approximate up, signed fixed point
// with FRAC_BITS fraction bits) is accepted at a rising edge where start is high
// and busy is low. The block answers with four result transactions, one per
// matrix column in order 0 to 3, each shown for exactly one cycle with rsp_valid
// high; rsp_last_column marks column 3 and rsp_degenerate marks an identity
// matrix forced by a zero-length forward or right axis.
// The other three columns follow column 0 in consecutive cycles.
// The pace of accepts is set by the single result channel, which carries
// one column per cycle. busy is high after each accept until the next
// accept is allowed. Many cameras are in flight at once in the deep pipeline
// (two normalizers with square root and divider stages, two cross product units
// and the translation stages).
// Synchronous reset empties the pipeline and drops busy; results in flight are
// lost. The receiver cannot stall the results.
module look_at_view_matrix #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  lav_pkg::coord_type            req_eye_x,
   input  lav_pkg::coord_type            req_eye_y,
   input  lav_pkg::coord_type            req_eye_z,
   input  lav_pkg::coord_type            req_center_x,
   input  lav_pkg::coord_type            req_center_y,
   input  lav_pkg::coord_type            req_center_z,
   input  lav_pkg::coord_type            req_up_hint_x,
   input  lav_pkg::coord_type            req_up_hint_y,
   input  lav_pkg::coord_type            req_up_hint_z,
   output logic                          rsp_valid,
   output logic [lav_pkg::COL_W-1:0]     rsp_column_index,
   output lav_pkg::coord_type            rsp_elem_row0,
   output lav_pkg::coord_type            rsp_elem_row1,
   output lav_pkg::coord_type            rsp_elem_row2,
   output lav_pkg::coord_type            rsp_elem_row3,
   output logic                          rsp_last_column,
   output logic                          rsp_degenerate
);

   localparam int DIR_W = lav_pkg::COORD_W + 1;

   // Accept pacing: busy holds off start after each accept.
   logic [lav_pkg::COL_W-1:0] gap_ff;
   logic                      accept;

   assign busy   = (gap_ff != '0);
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) gap_ff <= '0;
      else if (accept) gap_ff <= lav_pkg::ITEM_GAP;
      else if (busy) gap_ff <= gap_ff - 1'b1;
   end

   // Input stage: view direction and camera sideband.
   logic                  in_valid_ff;
   logic signed [DIR_W-1:0] dir_ff [3];
   lav_pkg::cam_side_type cam_ff;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= accept;
   end

   always_ff @(posedge clock) begin
      dir_ff[0]  <= DIR_W'(req_center_x) - DIR_W'(req_eye_x);
      dir_ff[1]  <= DIR_W'(req_center_y) - DIR_W'(req_eye_y);
      dir_ff[2]  <= DIR_W'(req_center_z) - DIR_W'(req_eye_z);
      cam_ff.eye <= '{req_eye_x, req_eye_y, req_eye_z};
      cam_ff.up  <= '{req_up_hint_x, req_up_hint_y, req_up_hint_z};
   end

   // Forward axis.
   logic                                f_valid;
   logic signed [lav_pkg::UNIT_W-1:0]   f_unit [3];
   logic                                f_zero;
   logic [$bits(lav_pkg::cam_side_type)-1:0] f_side_bits;
   lav_pkg::cam_side_type               f_side;
   lav_pkg::vec3_type                   f_vec;

   lav_unitize #(
      .IW(DIR_W), .SW($bits(lav_pkg::cam_side_type)), .FRAC_BITS(FRAC_BITS)
   ) u_fwd (
      .clock(clock), .reset(reset),
      .in_valid(in_valid_ff), .in_vec(dir_ff), .in_side(cam_ff),
      .out_valid(f_valid), .out_unit(f_unit), .out_zero(f_zero),
      .out_side(f_side_bits)
   );

   assign f_side = lav_pkg::cam_side_type'(f_side_bits);
   assign f_vec  = '{f_unit[0], f_unit[1], f_unit[2]};

   // Unnormalized right axis: forward cross up hint.
   lav_pkg::fwd_side_type                     rr_side_in;
   logic                                      rr_valid;
   lav_pkg::wide_type                         rr_vec [3];
   logic [$bits(lav_pkg::fwd_side_type)-1:0]  rr_side_bits;

   assign rr_side_in = '{eye: f_side.eye, fwd: f_vec, degen: f_zero};

   lav_cross #(.SW($bits(lav_pkg::fwd_side_type))) u_cross_right (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_a(f_vec), .in_b(f_side.up), .in_side(rr_side_in),
      .out_valid(rr_valid), .out_c(rr_vec), .out_side(rr_side_bits)
   );

   // Right axis.
   logic                                      r_valid;
   logic signed [lav_pkg::UNIT_W-1:0]         r_unit [3];
   logic                                      r_zero;
   logic [$bits(lav_pkg::fwd_side_type)-1:0]  r_side_bits;
   lav_pkg::fwd_side_type                     r_side;
   lav_pkg::vec3_type                         r_vec;

   lav_unitize #(
      .IW(lav_pkg::WIDE_W), .SW($bits(lav_pkg::fwd_side_type)), .FRAC_BITS(FRAC_BITS)
   ) u_right (
      .clock(clock), .reset(reset),
      .in_valid(rr_valid), .in_vec(rr_vec), .in_side(rr_side_bits),
      .out_valid(r_valid), .out_unit(r_unit), .out_zero(r_zero),
      .out_side(r_side_bits)
   );

   assign r_side = lav_pkg::fwd_side_type'(r_side_bits);
   assign r_vec  = '{r_unit[0], r_unit[1], r_unit[2]};

   // True up before rounding: right cross forward.
   lav_pkg::rgt_side_type                     u_side_in;
   logic                                      u_valid;
   lav_pkg::wide_type                         u_raw [3];
   logic [$bits(lav_pkg::rgt_side_type)-1:0]  u_side_bits;

   assign u_side_in = '{eye: r_side.eye, fwd: r_side.fwd, rgt: r_vec,
                        degen: r_side.degen | r_zero};

   lav_cross #(.SW($bits(lav_pkg::rgt_side_type))) u_cross_up (
      .clock(clock), .reset(reset),
      .in_valid(r_valid), .in_a(r_vec), .in_b(r_side.fwd), .in_side(u_side_in),
      .out_valid(u_valid), .out_c(u_raw), .out_side(u_side_bits)
   );

   // Translation column and column sequencing.
   lav_pkg::coord_type rows [lav_pkg::COLS];

   lav_emit #(.FRAC_BITS(FRAC_BITS)) u_emit (
      .clock(clock), .reset(reset),
      .in_valid(u_valid), .in_uraw(u_raw),
      .in_side(lav_pkg::rgt_side_type'(u_side_bits)),
      .out_valid(rsp_valid), .out_column(rsp_column_index), .out_row(rows),
      .out_last(rsp_last_column), .out_degen(rsp_degenerate)
   );

   assign rsp_elem_row0 = rows[0];
   assign rsp_elem_row1 = rows[1];
   assign rsp_elem_row2 = rows[2];
   assign rsp_elem_row3 = rows[3];

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the look-at view matrix block.
`timescale 1ns / 1ps

module tb_top;

   localparam int FRAC_BITS = 16;
   // Delay from the accepting edge to column 0; sets the quiet margin of the drain.
   localparam int LATENCY   = 2 * FRAC_BITS + 62;
   localparam longint ONE_FX = longint'(1) << FRAC_BITS;
   localparam lav_pkg::coord_type ONE_Q = lav_pkg::coord_type'(ONE_FX);

   typedef longint vec_l [3];

   // One expected column transaction on the result channel.
   typedef struct {
      logic [lav_pkg::COL_W-1:0] column_index;
      lav_pkg::coord_type        row0;
      lav_pkg::coord_type        row1;
      lav_pkg::coord_type        row2;
      lav_pkg::coord_type        row3;
      logic                      last_column;
      logic                      degenerate;
   } column_type;

   logic      clock;
   logic      reset;
   logic      start;
   logic      busy;
   lav_pkg::coord_type req_eye_x, req_eye_y, req_eye_z;
   lav_pkg::coord_type req_center_x, req_center_y, req_center_z;
   lav_pkg::coord_type req_up_hint_x, req_up_hint_y, req_up_hint_z;
   logic                      rsp_valid;
   logic [lav_pkg::COL_W-1:0] rsp_column_index;
   lav_pkg::coord_type        rsp_elem_row0, rsp_elem_row1, rsp_elem_row2, rsp_elem_row3;
   logic                      rsp_last_column;
   logic                      rsp_degenerate;

   // Columns that the block still owes us, oldest first.
   column_type pending_cols[$];
   int         mismatches = 0;

   look_at_view_matrix #(.FRAC_BITS(FRAC_BITS)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_eye_x(req_eye_x), .req_eye_y(req_eye_y), .req_eye_z(req_eye_z),
      .req_center_x(req_center_x), .req_center_y(req_center_y),
      .req_center_z(req_center_z),
      .req_up_hint_x(req_up_hint_x), .req_up_hint_y(req_up_hint_y),
      .req_up_hint_z(req_up_hint_z),
      .rsp_valid(rsp_valid), .rsp_column_index(rsp_column_index),
      .rsp_elem_row0(rsp_elem_row0), .rsp_elem_row1(rsp_elem_row1),
      .rsp_elem_row2(rsp_elem_row2), .rsp_elem_row3(rsp_elem_row3),
      .rsp_last_column(rsp_last_column), .rsp_degenerate(rsp_degenerate)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Integer square root, bit by bit, floor of the true root.
   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned root, bit_w;
      root  = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > n) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (n >= root + bit_w) begin
            n    = n - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   function automatic longint unsigned mag(input longint x);
      return (x < 0) ? longint'(-x) : longint'(x);
   endfunction

   // Fixed-point product correction: drop FRAC_BITS, ties away from zero.
   function automatic longint fx_round(input longint x);
      longint unsigned m;
      m = (mag(x) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      return (x < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clamp32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // Scales the magnitudes so the largest lies in [2^29, 2^30), then divides
   // each by the integer length. Returns 0 for a zero-length vector.
   function automatic bit normalize(input vec_l v, output vec_l u);
      longint unsigned m [3];
      longint unsigned big, sum, len, q;
      for (int i = 0; i < 3; i++) m[i] = mag(v[i]);
      big = m[0];
      if (m[1] > big) big = m[1];
      if (m[2] > big) big = m[2];
      for (int i = 0; i < 3; i++) u[i] = 0;
      if (big == 0) return 1'b0;
      while (big >= (64'd1 << 30)) begin
         big = big >> 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      end
      while (big < (64'd1 << 29)) begin
         big = big << 1;
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      end
      sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q    = ((m[i] << FRAC_BITS) + len / 2) / len;
         u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   // Works out the four columns of the view matrix for one camera and queues them.
   function automatic void predict_view(input lav_pkg::coord_type ex, ey, ez, cx, cy, cz,
                                        ux, uy, uz);
      vec_l eye, dir, up, fwd, rgt_raw, rgt, tup;
      longint col [4][4];
      bit degen;
      column_type c;
      eye = '{ex, ey, ez};
      dir = '{longint'(cx) - ex, longint'(cy) - ey, longint'(cz) - ez};
      up  = '{ux, uy, uz};
      degen = 1'b0;
      if (!normalize(dir, fwd)) begin
         degen = 1'b1;
      end else begin
         rgt_raw[0] = fwd[1] * up[2] - fwd[2] * up[1];
         rgt_raw[1] = fwd[2] * up[0] - fwd[0] * up[2];
         rgt_raw[2] = fwd[0] * up[1] - fwd[1] * up[0];
         if (!normalize(rgt_raw, rgt)) degen = 1'b1;
      end
      if (degen) begin
         for (int k = 0; k < 4; k++)
            for (int i = 0; i < 4; i++) col[k][i] = (i == k) ? ONE_FX : 0;
      end else begin
         tup[0] = fx_round(rgt[1] * fwd[2] - rgt[2] * fwd[1]);
         tup[1] = fx_round(rgt[2] * fwd[0] - rgt[0] * fwd[2]);
         tup[2] = fx_round(rgt[0] * fwd[1] - rgt[1] * fwd[0]);
         for (int k = 0; k < 3; k++) begin
            col[k][0] = rgt[k];
            col[k][1] = tup[k];
            col[k][2] = -fwd[k];
            col[k][3] = 0;
         end
         col[3][0] = clamp32(-fx_round(rgt[0] * eye[0] + rgt[1] * eye[1] + rgt[2] * eye[2]));
         col[3][1] = clamp32(-fx_round(tup[0] * eye[0] + tup[1] * eye[1] + tup[2] * eye[2]));
         col[3][2] = clamp32(fx_round(fwd[0] * eye[0] + fwd[1] * eye[1] + fwd[2] * eye[2]));
         col[3][3] = ONE_FX;
      end
      for (int k = 0; k < lav_pkg::COLS; k++) begin
         c.column_index = lav_pkg::COL_W'(k);
         c.row0 = lav_pkg::coord_type'(col[k][0]);
         c.row1 = lav_pkg::coord_type'(col[k][1]);
         c.row2 = lav_pkg::coord_type'(col[k][2]);
         c.row3 = lav_pkg::coord_type'(col[k][3]);
         c.last_column = (lav_pkg::COL_W'(k) == lav_pkg::LAST_COL);
         c.degenerate  = degen;
         pending_cols.push_back(c);
      end
   endfunction

   function automatic void check_field(input string name, input longint want,
                                       input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Every column transaction on the result channel is checked against the
   // oldest expectation. The receiver has no way to stall, so it simply samples.
   always @(posedge clock) begin
      column_type c;
      if (!reset && rsp_valid) begin
         if (pending_cols.size() == 0) begin
            $display("%0t: unexpected column %0d, expected none", $time,
                     rsp_column_index);
            mismatches++;
         end else begin
            c = pending_cols.pop_front();
            check_field("column_index", c.column_index, rsp_column_index);
            check_field("row0", c.row0, rsp_elem_row0);
            check_field("row1", c.row1, rsp_elem_row1);
            check_field("row2", c.row2, rsp_elem_row2);
            check_field("row3", c.row3, rsp_elem_row3);
            check_field("last_column", c.last_column, rsp_last_column);
            check_field("degenerate", c.degenerate, rsp_degenerate);
         end
      end
   end

   // Presents one camera and holds it until the block takes it. Start stays high
   // on return, so a back-to-back call simply keeps it high.
   task automatic send_camera(input lav_pkg::coord_type ex, ey, ez, cx, cy, cz,
                              ux, uy, uz);
      start         <= 1'b1;
      req_eye_x     <= ex;  req_eye_y    <= ey;  req_eye_z    <= ez;
      req_center_x  <= cx;  req_center_y <= cy;  req_center_z <= cz;
      req_up_hint_x <= ux;  req_up_hint_y <= uy; req_up_hint_z <= uz;
      do @(posedge clock); while (busy);
      predict_view(ex, ey, ez, cx, cy, cz, ux, uy, uz);
   endtask

   task automatic pause(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Burst shaping: mostly back to back, sometimes a gap of random length.
   int burst_left = 0;
   task automatic maybe_gap();
      if (burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         if ($urandom_range(3, 0) != 0) pause($urandom_range(9, 1));
      end
      burst_left--;
   endtask

   function automatic lav_pkg::coord_type rand_small();
      return lav_pkg::coord_type'($signed($urandom_range(2 ** 21, 0)) - 2 ** 20);
   endfunction

   // Axis-aligned cameras, full-scale fields, and a pair of opposite extremes.
   task automatic test_extremes();
      send_camera(0, 0, 0, 0, 0, -ONE_Q, 0, ONE_Q, 0);
      send_camera(0, 0, 0, ONE_Q, 0, 0, 0, 0, ONE_Q);
      send_camera(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h80000000,
                  32'h80000000, 32'h7fffffff, 32'h7fffffff);
      pause(3);
      send_camera(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_camera(32'hffffffff, 1, 32'hffffffff, 1, 32'hffffffff, 1,
                  32'hffffffff, 32'hffffffff, 1);
      send_camera(5, 7, -3, 6, 7, -3, 0, 1, 0);
      send_camera(32'h12345678, 32'hedcba987, 32'h0f0f0f0f,
                  32'h0, 32'h7fffffff, 32'h80000000, 32'h55555555, 32'haaaaaaaa, 0);
   endtask

   // Zero-length forward and zero-length right both force identity.
   task automatic test_degenerate();
      send_camera(100, 200, 300, 100, 200, 300, 0, ONE_Q, 0);
      send_camera(32'h80000000, 32'h7fffffff, 0, 32'h80000000, 32'h7fffffff, 0, 1, 1, 1);
      pause(2);
      send_camera(0, 0, 0, 5 * ONE_Q, 0, 0, 3 * ONE_Q, 0, 0);
      send_camera(0, 0, 0, 0, -ONE_Q, 0, 0, 32'h7fffffff, 0);
      send_camera(1, 2, 3, 4, 5, 6, 0, 0, 0);
      send_camera(0, 0, 0, 0, 0, 1, 0, 0, 32'h80000000);
   endtask

   // Eyes far out on a diagonal push the translation column past full scale.
   task automatic test_saturation();
      send_camera(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0, ONE_Q, 0);
      send_camera(32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, ONE_Q, 0, 0);
      pause(1);
      send_camera(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0, 0, ONE_Q);
      send_camera(32'h80000000, 32'h7fffffff, 32'h80000000,
                  32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, ONE_Q, 0);
      send_camera(32'h7fff0000, 32'h7fff0000, 32'h80010000, 0, 0, 0, ONE_Q, ONE_Q, 0);
   endtask

   // Mostly well-formed cameras at moderate scale, plus full-range noise,
   // degenerate geometry and far-out eyes.
   task automatic test_random(input int count);
      lav_pkg::coord_type ex, ey, ez, cx, cy, cz, ux, uy, uz;
      int kind, scale;
      repeat (count) begin
         kind = $urandom_range(99, 0);
         ex = rand_small(); ey = rand_small(); ez = rand_small();
         cx = rand_small(); cy = rand_small(); cz = rand_small();
         ux = rand_small(); uy = rand_small(); uz = rand_small();
         if (kind < 20) begin
            ex = $urandom(); ey = $urandom(); ez = $urandom();
            cx = $urandom(); cy = $urandom(); cz = $urandom();
            ux = $urandom(); uy = $urandom(); uz = $urandom();
         end else if (kind < 27) begin
            cx = ex; cy = ey; cz = ez;
         end else if (kind < 34) begin
            // Up along an axis, forward along the same axis.
            scale = $urandom_range(1000, 1);
            cx = ex; cy = ey; cz = ez; ux = 0; uy = 0; uz = 0;
            case ($urandom_range(2, 0))
               0: begin cx = ex + scale; ux = scale * ($urandom_range(1, 0) ? 1 : -1); end
               1: begin cy = ey - scale; uy = scale; end
               default: begin cz = ez + scale; uz = -scale; end
            endcase
         end else if (kind < 38) begin
            ux = 0; uy = 0; uz = 0;
         end else if (kind < 50) begin
            ex = $urandom(); ey = $urandom(); ez = $urandom();
         end else if (kind < 60) begin
            cx = ex + $signed($urandom_range(6, 0)) - 3;
            cy = ey + $signed($urandom_range(6, 0)) - 3;
            cz = ez + $signed($urandom_range(6, 0)) - 3;
         end
         maybe_gap();
         send_camera(ex, ey, ez, cx, cy, cz, ux, uy, uz);
      end
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_eye_x     = '0; req_eye_y    = '0; req_eye_z    = '0;
      req_center_x  = '0; req_center_y = '0; req_center_z = '0;
      req_up_hint_x = '0; req_up_hint_y = '0; req_up_hint_z = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_degenerate();
      test_saturation();
      test_random(265);
      pause(1);

      // Drain: every column still owed must arrive, then a quiet margin.
      while (pending_cols.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #400000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// File: filelist.f
design/lav_pkg.sv
design/lav_unitize.sv
design/lav_cross.sv
design/lav_emit.sv
design/look_at_view_matrix.sv
tb/tb_top.sv
